/* rtl/m3i_pkg.sv */
// shared constants, command and status types, cofactor lookup table and address functions for the 3x3 inverse block
`default_nettype none
package m3i_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_ELEM       = 9;
	localparam int ADDR_W         = $clog2(NUM_ELEM);
	localparam int IDX_W          = 4;

	// element indexes with a meaning of their own
	localparam logic [IDX_W-1:0] LAST_IDX   = 4'd8;
	localparam logic [IDX_W-1:0] DET_STEP   = 4'd3;
	localparam logic [IDX_W-1:0] DET_LAST_K = 4'd6;
	localparam logic [IDX_W-1:0] DET_MID_K  = 4'd3;

	// adjugate entry k = e[a]*e[b] - e[c]*e[d]
	localparam logic [ADDR_W-1:0] COF_TAB [NUM_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] raddr;
		logic              ld_a_elem;
		logic              ld_a_cof;
		logic              ld_b_start;
		logic              mul_step;
		logic              save_t1;
		logic              save_cof;
		logic              det_clear;
		logic              det_acc;
		logic              det_fin;
		logic              div_start;
		logic              div_step;
		logic              out_load;
		logic [IDX_W-1:0]  k;
		logic              last;
	} m3i_cmd_t;

	typedef struct packed {
		logic iter_last;
	} m3i_sts_t;

	function automatic logic [ADDR_W-1:0] cof_addr(input logic [IDX_W-1:0] k,
		input logic [1:0] sel);
		return COF_TAB[k][sel];
	endfunction

	// row-0 element that multiplies adjugate entry k (k = 0, 3, 6)
	function automatic logic [ADDR_W-1:0] det_addr(input logic [IDX_W-1:0] k);
		logic [ADDR_W-1:0] a;
		a = 4'd2;
		if (k == '0)
			a = 4'd0;
		else if (k == DET_MID_K)
			a = 4'd1;
		return a;
	endfunction

endpackage
`default_nettype wire

/* rtl/m3i_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module m3i_ram #(
	parameter int WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
	parameter int DEPTH = m3i_pkg::NUM_ELEM
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/m3i_dp.sv */
// datapath: element store, shift-add multiplier, determinant accumulator, restoring divider
`default_nettype none
module m3i_dp #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire m3i_pkg::m3i_cmd_t             cmd,
	output m3i_pkg::m3i_sts_t                  sts,
	input  wire logic signed [ELEM_WIDTH-1:0]  element_value,
	input  wire logic [m3i_pkg::IDX_W-1:0]     element_index,
	output logic signed [ELEM_WIDTH-1:0]       inverse_value,
	output logic [m3i_pkg::IDX_W-1:0]          out_index,
	output logic signed [ELEM_WIDTH-1:0]       determinant,
	output logic                               singular,
	output logic                               saturated,
	output logic                               last
);

	localparam int W    = ELEM_WIDTH;
	localparam int CW   = 2 * W + 1;
	localparam int PW   = 3 * W;
	localparam int DW   = 3 * W + 2;
	localparam int NW   = 2 * W + 2 * FRAC_BITS;
	localparam int CNTW = $clog2(NW);

	logic [W-1:0]    rdata;
	logic            elem_neg;
	logic [W-1:0]    elem_mag;

	logic [2*W-1:0]  a_q;
	logic            sa_q;
	logic            sb_q;
	logic [PW-1:0]   prod_q;
	logic [CNTW-1:0] cnt_q;
	logic [2*W:0]    mul_sum;
	logic            psign;
	logic [CW-1:0]   pc_mag;
	logic [CW-1:0]   prod_c;
	logic [DW-1:0]   prod_d;

	logic [CW-1:0]   t1_q;
	logic [CW-1:0]   cof_q;
	logic [CW-1:0]   cof_abs;
	logic [DW-1:0]   det_q;
	logic [DW-1:0]   det_abs;
	logic [PW-1:0]   det_sh;
	logic [PW-1:0]   det_lim;
	logic            det_over;
	logic [PW-1:0]   det_clip;
	logic [W-1:0]    det_field;

	logic [PW-1:0]   dmag_q;
	logic            dneg_q;
	logic [W-1:0]    detf_q;
	logic            dsat_q;
	logic            sing_q;

	logic [PW-1:0]   rem_q;
	logic [NW-1:0]   nq_q;
	logic            qneg_q;
	logic [PW:0]     rem_sh;
	logic [PW:0]     rem_dif;
	logic            rem_ge;
	logic [NW-1:0]   q_lim;
	logic            q_over;
	logic [NW-1:0]   q_clip;
	logic [W-1:0]    q_field;

	logic [W-1:0]                 inv_q;
	logic [m3i_pkg::IDX_W-1:0]    oidx_q;
	logic                         sat_q;
	logic                         last_q;

	m3i_ram #(
		.WIDTH(W),
		.DEPTH(m3i_pkg::NUM_ELEM)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(element_index[m3i_pkg::ADDR_W-1:0]),
		.wdata(element_value),
		.raddr(cmd.raddr),
		.rdata(rdata)
	);

	assign elem_neg = rdata[W-1];
	assign elem_mag = elem_neg ? (~rdata + W'(1)) : rdata;

	// one add per step, product shifts right past the multiplier bits
	assign mul_sum = {1'b0, prod_q[PW-1:W]} + (prod_q[0] ? {1'b0, a_q} : '0);
	assign psign   = sa_q ^ sb_q;
	assign pc_mag  = {1'b0, prod_q[2*W-1:0]};
	assign prod_c  = psign ? (~pc_mag + CW'(1)) : pc_mag;
	assign prod_d  = psign ? (~{2'b00, prod_q} + DW'(1)) : {2'b00, prod_q};

	assign cof_abs = cof_q[CW-1] ? (~cof_q + CW'(1)) : cof_q;

	// determinant field: magnitude truncated, clipped, sign restored
	assign det_abs   = det_q[DW-1] ? (~det_q + DW'(1)) : det_q;
	assign det_sh    = det_abs[PW-1:0] >> (2 * FRAC_BITS);
	assign det_lim   = (PW'(1) << (W - 1)) - PW'(!det_q[DW-1]);
	assign det_over  = det_sh > det_lim;
	assign det_clip  = det_over ? det_lim : det_sh;
	assign det_field = det_q[DW-1] ? (~det_clip[W-1:0] + W'(1)) : det_clip[W-1:0];

	// restoring divide, one quotient bit per step
	assign rem_sh  = {rem_q, nq_q[NW-1]};
	assign rem_dif = rem_sh - {1'b0, dmag_q};
	assign rem_ge  = rem_sh >= {1'b0, dmag_q};

	assign q_lim   = (NW'(1) << (W - 1)) - NW'(!qneg_q);
	assign q_over  = nq_q > q_lim;
	assign q_clip  = q_over ? q_lim : nq_q;
	assign q_field = qneg_q ? (~q_clip[W-1:0] + W'(1)) : q_clip[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.ld_a_elem) begin
			a_q  <= {{W{1'b0}}, elem_mag};
			sa_q <= elem_neg;
		end else if (cmd.ld_a_cof) begin
			a_q  <= cof_abs[2*W-1:0];
			sa_q <= cof_q[CW-1];
		end
		if (cmd.ld_b_start) begin
			prod_q <= {{(2*W){1'b0}}, elem_mag};
			sb_q   <= elem_neg;
			cnt_q  <= CNTW'(W - 1);
		end else if (cmd.mul_step) begin
			prod_q <= {mul_sum, prod_q[W-1:1]};
			cnt_q  <= cnt_q - CNTW'(1);
		end else if (cmd.div_start) begin
			cnt_q  <= CNTW'(NW - 1);
		end else if (cmd.div_step) begin
			cnt_q  <= cnt_q - CNTW'(1);
		end
		if (cmd.save_t1)
			t1_q <= prod_c;
		if (cmd.save_cof)
			cof_q <= t1_q - prod_c;
		if (cmd.det_clear)
			det_q <= '0;
		else if (cmd.det_acc)
			det_q <= det_q + prod_d;
		if (cmd.det_fin) begin
			dmag_q <= det_abs[PW-1:0];
			dneg_q <= det_q[DW-1];
			detf_q <= det_field;
			dsat_q <= det_over;
			sing_q <= det_q == '0;
		end
		if (cmd.div_start) begin
			nq_q   <= {cof_abs[2*W-1:0], {(2*FRAC_BITS){1'b0}}};
			rem_q  <= '0;
			qneg_q <= cof_q[CW-1] ^ dneg_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_dif[PW-1:0] : rem_sh[PW-1:0];
			nq_q  <= {nq_q[NW-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			inv_q  <= sing_q ? '0 : q_field;
			sat_q  <= sing_q ? dsat_q : (q_over | dsat_q);
			oidx_q <= cmd.k;
			last_q <= cmd.last;
		end
	end

	assign sts.iter_last = cnt_q == '0;

	assign inverse_value = inv_q;
	assign out_index     = oidx_q;
	assign determinant   = detf_q;
	assign singular      = sing_q;
	assign saturated     = sat_q;
	assign last          = last_q;

endmodule
`default_nettype wire

/* rtl/m3i_ctrl.sv */
// controller: sequences loads, products, determinant, divisions and output handshake
`default_nettype none
module m3i_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      elem_valid,
	output logic                           elem_stall,
	input  wire logic [m3i_pkg::IDX_W-1:0] element_index,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output m3i_pkg::m3i_cmd_t              cmd,
	input  wire m3i_pkg::m3i_sts_t         sts
);

	typedef enum logic [3:0] {
		S_IDLE, S_RA, S_RB, S_MB, S_MUL, S_P1, S_P2, S_DRA,
		S_DMB, S_DACC, S_DFIN, S_DVLD, S_DIV, S_LOAD, S_OUT
	} state_t;

	state_t                    state_q, state_d;
	logic [m3i_pkg::IDX_W-1:0] k_q, k_d;
	logic                      half_q, half_d;
	logic                      dpass_q, dpass_d;
	logic                      dmul_q, dmul_d;
	logic                      res_valid_q, res_valid_d;
	logic                      accept;

	assign elem_stall = state_q != S_IDLE;
	assign accept     = elem_valid && !elem_stall;
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.k       = k_q;
		cmd.last    = k_q == m3i_pkg::LAST_IDX;
		state_d     = state_q;
		k_d         = k_q;
		half_d      = half_q;
		dpass_d     = dpass_q;
		dmul_d      = dmul_q;
		res_valid_d = res_valid_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.wr_en = accept && (element_index <= m3i_pkg::LAST_IDX);
				if (accept && element_index == m3i_pkg::LAST_IDX) begin
					cmd.det_clear = 1'b1;
					k_d     = '0;
					half_d  = 1'b0;
					dpass_d = 1'b1;
					state_d = S_RA;
				end
			end
			S_RA: begin
				cmd.raddr = m3i_pkg::cof_addr(k_q, {half_q, 1'b0});
				state_d   = S_RB;
			end
			S_RB: begin
				cmd.raddr     = m3i_pkg::cof_addr(k_q, {half_q, 1'b1});
				cmd.ld_a_elem = 1'b1;
				state_d       = S_MB;
			end
			S_MB: begin
				cmd.ld_b_start = 1'b1;
				dmul_d  = 1'b0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.iter_last) begin
					if (dmul_q)
						state_d = S_DACC;
					else if (half_q)
						state_d = S_P2;
					else
						state_d = S_P1;
				end
			end
			S_P1: begin
				cmd.save_t1 = 1'b1;
				half_d  = 1'b1;
				state_d = S_RA;
			end
			S_P2: begin
				cmd.save_cof = 1'b1;
				half_d  = 1'b0;
				state_d = dpass_q ? S_DRA : S_DVLD;
			end
			S_DRA: begin
				cmd.raddr = m3i_pkg::det_addr(k_q);
				state_d   = S_DMB;
			end
			S_DMB: begin
				cmd.ld_a_cof   = 1'b1;
				cmd.ld_b_start = 1'b1;
				dmul_d  = 1'b1;
				state_d = S_MUL;
			end
			S_DACC: begin
				cmd.det_acc = 1'b1;
				dmul_d = 1'b0;
				if (k_q == m3i_pkg::DET_LAST_K) begin
					state_d = S_DFIN;
				end else begin
					k_d     = k_q + m3i_pkg::DET_STEP;
					state_d = S_RA;
				end
			end
			S_DFIN: begin
				cmd.det_fin = 1'b1;
				k_d     = '0;
				dpass_d = 1'b0;
				state_d = S_RA;
			end
			S_DVLD: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.iter_last)
					state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.out_load = 1'b1;
				res_valid_d  = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!res_stall) begin
					res_valid_d = 1'b0;
					if (k_q == m3i_pkg::LAST_IDX) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + m3i_pkg::IDX_W'(1);
						state_d = S_RA;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			half_q      <= 1'b0;
			dpass_q     <= 1'b0;
			dmul_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			half_q      <= half_d;
			dpass_q     <= dpass_d;
			dmul_q      <= dmul_d;
			res_valid_q <= res_valid_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/matrix3_inverse_determinant.sv */
// top level of the 3x3 fixed-point matrix inverse and determinant block
// Loads a 3x3 matrix one element word at a time (signed Q16.16 by default, row-major index
// 0 to 8); indexes above 8 are dropped. The word with index 8 starts the run: the block
// forms the exact determinant by row-0 cofactor expansion, then for each of the nine
// adjugate entries divides cofactor * 2^(2*FRAC_BITS) by the determinant, truncating toward
// zero and clipping to ELEM_WIDTH bits, and emits nine result words in row-major order.
// Every result word carries the clipped determinant, a singular flag (exact zero
// determinant, all inverse values zero), a saturated flag and last on the ninth word.
// Element words are taken back to back while the block is idle. Products come from the one
// radix-2 shift-add multiplier (2 products per adjugate entry, 9 entries, plus 3 for the
// determinant, whose pass also forms adjugate entries 0, 3 and 6 a first time) and quotients
// from the one restoring divider (2*W + 2*F quotient bits per entry with W = ELEM_WIDTH and
// F = FRAC_BITS, 96 bits at Q16.16). While a run is in progress the block holds elem_stall
// high; each result word is held until taken.
`default_nettype none
module matrix3_inverse_determinant #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// element input channel
	input  wire logic                         elem_valid,
	output logic                              elem_stall,
	input  wire logic signed [ELEM_WIDTH-1:0] element_value,
	input  wire logic [m3i_pkg::IDX_W-1:0]    element_index,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic signed [ELEM_WIDTH-1:0]      inverse_value,
	output logic [m3i_pkg::IDX_W-1:0]         out_index,
	output logic signed [ELEM_WIDTH-1:0]      determinant,
	output logic                              singular,
	output logic                              saturated,
	output logic                              last
);

	m3i_pkg::m3i_cmd_t cmd;
	m3i_pkg::m3i_sts_t sts;

	// sequencer: owns both handshakes and drives the datapath commands
	m3i_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem_valid),
		.elem_stall   (elem_stall),
		.element_index(element_index),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	// store, multiplier, determinant and divider
	m3i_dp #(
		.ELEM_WIDTH(ELEM_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.element_value(element_value),
		.element_index(element_index),
		.inverse_value(inverse_value),
		.out_index    (out_index),
		.determinant  (determinant),
		.singular     (singular),
		.saturated    (saturated),
		.last         (last)
	);

	// no element word is taken while a result word waits
	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> elem_stall)
		else $error("element accepted while a result word is pending");

	// a singular matrix gives zero inverse values and a zero, unclipped determinant
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && singular) |-> (inverse_value == '0 && determinant == '0 && !saturated))
		else $error("singular result with nonzero fields");

	// a taken result word other than the last is followed by a busy block, not idle
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last) |=> (elem_stall && !res_valid))
		else $error("run ended before the ninth result word");

endmodule
`default_nettype wire

/* dv/tb_matrix3_inverse_determinant.sv */
// testbench for the 3x3 fixed-point matrix inverse and determinant block
`default_nettype none
module tb_matrix3_inverse_determinant;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	// one element word on its way in
	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         index;
	} elem_word_t;

	// one inverse element word as the block should emit it
	typedef struct {
		logic signed [31:0] inv;
		logic [3:0]         idx;
		logic signed [31:0] det;
		logic               sing;
		logic               sat;
		logic               last;
	} inv_word_t;

	// adjugate entry k = e[a]*e[b] - e[c]*e[d]
	localparam int ADJ_TERMS [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] MAX_Q16 = 32'sh7fff_ffff;
	localparam logic signed [31:0] MIN_Q16 = 32'sh8000_0000;
	localparam int IDLE_PCT = 38;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               elem_valid = 1'b0;
	logic               elem_stall;
	logic signed [31:0] element_value = '0;
	logic [3:0]         element_index = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [31:0] inverse_value;
	logic [3:0]         out_index;
	logic signed [31:0] determinant;
	logic               singular;
	logic               saturated;
	logic               last;

	matrix3_inverse_determinant u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem_valid),
		.elem_stall   (elem_stall),
		.element_value(element_value),
		.element_index(element_index),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.inverse_value(inverse_value),
		.out_index    (out_index),
		.determinant  (determinant),
		.singular     (singular),
		.saturated    (saturated),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	elem_word_t         pending_words[$];
	inv_word_t          expected_inverse[$];
	logic signed [31:0] shadow_matrix[9];
	int                 errors = 0;
	int                 cycle_no = 0;
	logic               quiet;

	// idling is switched off for a long stretch in the middle of the run
	assign quiet = (cycle_no >= 6000) && (cycle_no < 14000);

	always @(posedge clk) cycle_no <= cycle_no + 1;

	// clip a wide value to the signed 32-bit range, flag when clipped
	function automatic logic signed [31:0] clip32(input wide_t x, inout logic s);
		if (x > wide_t'(MAX_Q16)) begin
			s = 1'b1;
			return MAX_Q16;
		end
		if (x < wide_t'(MIN_Q16)) begin
			s = 1'b1;
			return MIN_Q16;
		end
		return x[31:0];
	endfunction

	// store one word and, on index 8, work out the nine inverse words
	task automatic predict_inverse(input logic signed [31:0] v, input logic [3:0] ix);
		wide_t     e[9];
		wide_t     det;
		wide_t     cof;
		logic      dsat;
		logic      esat;
		logic      sing;
		inv_word_t w;
		logic signed [31:0] dfield;
		if (ix > 4'd8)
			return;
		shadow_matrix[ix] = v;
		if (ix != 4'd8)
			return;
		for (int i = 0; i < 9; i++)
			e[i] = shadow_matrix[i];
		// rule of sarrus, exact
		det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
			- e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
		sing = (det == 0);
		dsat = 1'b0;
		// signed division truncates toward zero
		dfield = clip32(det / (wide_t'(1) <<< 32), dsat);
		for (int k = 0; k < 9; k++) begin
			esat = 1'b0;
			w.inv = '0;
			if (!sing) begin
				cof = e[ADJ_TERMS[k][0]]*e[ADJ_TERMS[k][1]]
					- e[ADJ_TERMS[k][2]]*e[ADJ_TERMS[k][3]];
				w.inv = clip32((cof <<< 32) / det, esat);
			end
			w.idx  = 4'(k);
			w.det  = dfield;
			w.sing = sing;
			w.sat  = esat | dsat;
			w.last = (k == 8);
			expected_inverse.push_back(w);
		end
	endtask

	// driver: next word goes out once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_valid    <= 1'b0;
			element_value <= '0;
			element_index <= '0;
		end else if (!elem_valid || !elem_stall) begin
			if (elem_valid)
				predict_inverse(element_value, element_index);
			if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				element_value <= pending_words[0].value;
				element_index <= pending_words[0].index;
				elem_valid    <= 1'b1;
				void'(pending_words.pop_front());
			end else begin
				elem_valid <= 1'b0;
			end
		end
	end

	// result side stall, random except during the quiet stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// monitor: compare each taken word with the oldest expectation
	always @(posedge clk) begin
		inv_word_t w;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_inverse.size() == 0) begin
				$error("result word with nothing expected, out_index %0d", out_index);
				errors++;
			end else begin
				w = expected_inverse.pop_front();
				if (inverse_value !== w.inv) begin
					$error("inverse_value expected %0d actual %0d", w.inv, inverse_value);
					errors++;
				end
				if (out_index !== w.idx) begin
					$error("out_index expected %0d actual %0d", w.idx, out_index);
					errors++;
				end
				if (determinant !== w.det) begin
					$error("determinant expected %0d actual %0d", w.det, determinant);
					errors++;
				end
				if (singular !== w.sing) begin
					$error("singular expected %0d actual %0d", w.sing, singular);
					errors++;
				end
				if (saturated !== w.sat) begin
					$error("saturated expected %0d actual %0d", w.sat, saturated);
					errors++;
				end
				if (last !== w.last) begin
					$error("last expected %0d actual %0d", w.last, last);
					errors++;
				end
			end
		end
	end

	// random element: small magnitudes, full range, or the extremes
	function automatic logic signed [31:0] pick_elem(input int mode);
		case (mode)
			0: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			1: return $urandom;
			default: begin
				case ($urandom_range(4))
					0: return MAX_Q16;
					1: return MIN_Q16;
					2: return ONE_Q16;
					3: return -ONE_Q16;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	int words_sent = 0;

	task automatic queue_word(input logic signed [31:0] v, input logic [3:0] ix);
		elem_word_t w;
		w.value = v;
		w.index = ix;
		pending_words.push_back(w);
		words_sent++;
	endtask

	// whole matrix, indexes 0..7 in random order when shuffled, 8 last
	task automatic queue_matrix(input logic signed [31:0] m[9], input bit shuffle);
		int ord[8];
		int j;
		int t;
		for (int i = 0; i < 8; i++)
			ord[i] = i;
		if (shuffle)
			for (int i = 7; i > 0; i--) begin
				j = $urandom_range(i);
				t = ord[i];
				ord[i] = ord[j];
				ord[j] = t;
			end
		for (int i = 0; i < 8; i++)
			queue_word(m[ord[i]], 4'(ord[i]));
		queue_word(m[8], 4'd8);
	endtask

	initial begin
		logic signed [31:0] m[9];
		int mode;
		int r;

		// identity in q16.16
		m = '{ONE_Q16, 0, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16};
		queue_matrix(m, 1'b0);
		// ignored indexes between loads
		for (int i = 9; i < 16; i++)
			queue_word($urandom, 4'(i));
		// zero matrix, singular
		m = '{default: 0};
		queue_matrix(m, 1'b0);
		// tiny determinant: nonzero but truncates to zero, inverse clips
		queue_word(32'sd1, 4'd0);
		queue_word(32'sd1, 4'd4);
		queue_word(32'sd1, 4'd8);
		// largest and smallest elements
		queue_word(MAX_Q16, 4'd0);
		queue_word(MIN_Q16, 4'd4);
		queue_word(MAX_Q16, 4'd8);
		m = '{MIN_Q16, MAX_Q16, 0, 0, MIN_Q16, MAX_Q16, MAX_Q16, 0, MIN_Q16};
		queue_matrix(m, 1'b0);

		// random part, mostly whole matrices with random content
		while (words_sent < 100) begin
			r = $urandom_range(99);
			mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
			if (r < 70) begin
				for (int i = 0; i < 9; i++)
					m[i] = pick_elem(mode);
				// sometimes repeat a row so the matrix is singular
				if ($urandom_range(4) == 0)
					for (int c = 0; c < 3; c++)
						m[6 + c] = m[c];
				queue_matrix(m, 1'b1);
			end else if (r < 85) begin
				// rewrite a few entries, then recompute
				repeat ($urandom_range(1, 3))
					queue_word(pick_elem(mode), 4'($urandom_range(7)));
				queue_word(pick_elem(mode), 4'd8);
			end else begin
				repeat ($urandom_range(1, 3))
					queue_word($urandom, 4'($urandom_range(9, 15)));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all words taken, all results in, then a drain pause
		while (pending_words.size() > 0 || elem_valid || expected_inverse.size() > 0)
			@(posedge clk);
		repeat (2500) @(posedge clk);
		if (errors == 0 && expected_inverse.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#8ms;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
